[hdl/aux_pf_pkg.sv]
package aux_pf_pkg;

   localparam int MAX_PAYLOAD    = 8;
   localparam int HEADER_BYTES   = 5;
   localparam int STORE_DEPTH    = HEADER_BYTES + MAX_PAYLOAD;
   localparam int BYTE_W         = 8;
   localparam int SIZE_W         = 4;
   localparam int REQ_TDATA_W    = 88;
   localparam int PAYLOAD_LSB    = 2 * BYTE_W + SIZE_W;
   localparam int CSR_ADDR_W     = 1;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] REG_PREAMBLE = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] REG_SOURCE   = 1'b1;

   // chain control, shared by every cell
   typedef struct packed {
      logic load;
      logic shift;
   } chain_ctrl_type;

endpackage

[hdl/aux_pf_cell.sv]
module aux_pf_cell (
   input  logic                             clock,
   input  logic                             reset,
   input  aux_pf_pkg::chain_ctrl_type       ctrl,
   input  logic [aux_pf_pkg::BYTE_W-1:0]    load_byte,
   input  logic                             load_valid,
   input  logic [aux_pf_pkg::BYTE_W-1:0]    next_byte,
   input  logic                             next_valid,
   output logic [aux_pf_pkg::BYTE_W-1:0]    cell_byte,
   output logic                             cell_valid
);

   logic [aux_pf_pkg::BYTE_W-1:0] byte_ff, byte_in;
   logic                          valid_ff, valid_in;

   always_comb begin
      byte_in  = byte_ff;
      valid_in = valid_ff;
      if (ctrl.load) begin
         byte_in  = load_byte;
         valid_in = load_valid;
      end else if (ctrl.shift) begin
         byte_in  = next_byte;
         valid_in = next_valid;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign cell_byte  = byte_ff;
   assign cell_valid = valid_ff;

endmodule

[hdl/aux_packet_framer.sv]
// aux_packet_framer
// Takes one command request on req_* and sends the frame a byte per request
// on rsp_*: preamble, length (size + 3), source address, destination, id,
// the payload bytes, then the checksum (negated byte sum, length to last
// payload byte), with rsp_tlast on the checksum.
// A payload size above MAX_PAYLOAD gives one request with tdata zero,
// tlast and tuser (size error) high, and no frame.
// The command loads a row of 13 byte cells at once; the row then shifts
// towards cell 0 one byte per cycle, while rsp_tready allows, into the
// output register, and the checksum accumulates as bytes leave; the first
// byte is registered there after the load. The next command is taken as
// soon as the checksum sits in the output register, while it waits to be
// taken. A stalled rsp_tready freezes the row; nothing is lost.
// csr_*: write index 0 preamble, 1 source address; write only while idle.
// Reset (synchronous, active high) empties the row and output register and
// restores preamble 59 and source address 13.
module aux_packet_framer (
   input  logic                                  clock,
   input  logic                                  reset,
   // req_tdata, from bit 0: dest_address[8], command_id[8], payload_size[4],
   // payload_0..payload_7 [8 each], zero fill[4]
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [aux_pf_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // rsp_tdata: frame_byte[8]; rsp_tuser: size_error; rsp_tlast: last_byte
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [aux_pf_pkg::BYTE_W-1:0]         rsp_tdata,
   output logic                                  rsp_tlast,
   output logic                                  rsp_tuser,
   input  logic                                  csr_we,
   input  logic [aux_pf_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [aux_pf_pkg::BYTE_W-1:0]         csr_wdata
);

   localparam int DEPTH = aux_pf_pkg::STORE_DEPTH;
   localparam int BW    = aux_pf_pkg::BYTE_W;

   typedef enum logic [1:0] {IDLE, SEND, CSUM, ERR} state_type;

   state_type   state_ff, state_in;
   logic [BW-1:0] preamble_ff, source_ff;
   logic [BW-1:0] sum_ff, sum_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [BW-1:0] rsp_data_ff, rsp_data_in;
   logic          rsp_last_ff, rsp_last_in;
   logic          rsp_err_ff, rsp_err_in;

   logic [aux_pf_pkg::SIZE_W-1:0] req_size;
   logic          req_take, size_bad, out_free;
   aux_pf_pkg::chain_ctrl_type ctrl;

   logic [BW-1:0] load_byte [DEPTH];
   logic          load_valid [DEPTH];
   logic [BW-1:0] cell_byte [DEPTH+1];
   logic          cell_valid [DEPTH+1];

   assign req_size   = req_tdata[2*BW +: aux_pf_pkg::SIZE_W];
   assign size_bad   = req_size > aux_pf_pkg::SIZE_W'(aux_pf_pkg::MAX_PAYLOAD);
   assign req_tready = (state_ff == IDLE);
   assign req_take   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign ctrl.load  = req_take && !size_bad;
   assign ctrl.shift = (state_ff == SEND) && out_free;

   // end of the row reads as empty
   assign cell_byte[DEPTH]  = '0;
   assign cell_valid[DEPTH] = 1'b0;

   // header cells
   assign load_byte[0]  = preamble_ff;
   assign load_byte[1]  = BW'(req_size) + BW'(3);
   assign load_byte[2]  = source_ff;
   assign load_byte[3]  = req_tdata[0 +: BW];
   assign load_byte[4]  = req_tdata[BW +: BW];
   assign load_valid[0] = 1'b1;
   assign load_valid[1] = 1'b1;
   assign load_valid[2] = 1'b1;
   assign load_valid[3] = 1'b1;
   assign load_valid[4] = 1'b1;

   genvar gi;
   generate
      for (gi = aux_pf_pkg::HEADER_BYTES; gi < DEPTH; gi++) begin : g_payload
         localparam int K = gi - aux_pf_pkg::HEADER_BYTES;
         assign load_byte[gi]  = req_tdata[aux_pf_pkg::PAYLOAD_LSB + K*BW +: BW];
         assign load_valid[gi] = req_size > aux_pf_pkg::SIZE_W'(K);
      end
      for (gi = 0; gi < DEPTH; gi++) begin : g_cell
         aux_pf_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (ctrl),
            .load_byte  (load_byte[gi]),
            .load_valid (load_valid[gi]),
            .next_byte  (cell_byte[gi+1]),
            .next_valid (cell_valid[gi+1]),
            .cell_byte  (cell_byte[gi]),
            .cell_valid (cell_valid[gi])
         );
      end
   endgenerate

   always_comb begin
      state_in     = state_ff;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_err_in   = rsp_err_ff;
      case (state_ff)
         IDLE: begin
            if (req_take) begin
               // preamble is not summed: start the sum at its negative
               sum_in   = 8'd0 - preamble_ff;
               state_in = size_bad ? ERR : SEND;
            end
         end
         SEND: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = cell_byte[0];
               rsp_last_in  = 1'b0;
               rsp_err_in   = 1'b0;
               sum_in       = sum_ff + cell_byte[0];
               if (!cell_valid[1]) begin
                  state_in = CSUM;
               end
            end
         end
         CSUM: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = 8'd0 - sum_ff;
               rsp_last_in  = 1'b1;
               rsp_err_in   = 1'b0;
               state_in     = IDLE;
            end
         end
         ERR: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               rsp_last_in  = 1'b1;
               rsp_err_in   = 1'b1;
               state_in     = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      sum_ff      <= sum_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      rsp_err_ff  <= rsp_err_in;
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
         preamble_ff  <= 8'd59;
         source_ff    <= 8'd13;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we && csr_addr == aux_pf_pkg::REG_PREAMBLE) begin
            preamble_ff <= csr_wdata;
         end
         if (csr_we && csr_addr == aux_pf_pkg::REG_SOURCE) begin
            source_ff <= csr_wdata;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_err_ff;

   // size error always ends its own one-request run
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast && rsp_tdata == '0)
      else $error("size error request without tlast or with data");

   // a taken command leaves idle
   a_take_busy: assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff != IDLE)
      else $error("command taken but framer stayed idle");

   // while sending, the head cell holds a byte
   a_head_valid: assert property (@(posedge clock) disable iff (reset)
      state_ff == SEND |-> cell_valid[0])
      else $error("sending with an empty cell row");

   // row is empty whenever a new command can be taken
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      state_ff == IDLE |-> !cell_valid[0])
      else $error("idle with bytes left in the row");

endmodule
